// File: design/lbca_pkg.sv
// shared types and codes for the linked block chain allocator
`timescale 1ns / 1ps

package lbca_pkg;

    localparam int LEN_W = 14;

    localparam logic [2:0] CMD_CREATE = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_OPEN   = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_DELETE = 3'd4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_SPACE = 3'd1,
        ST_UNUSED   = 3'd2,
        ST_NOT_HEAD = 3'd3,
        ST_NO_XFER  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_WRITE,
        OP_OPEN,
        OP_READ,
        OP_DELETE,
        OP_NONE
    } op_t;

    typedef enum logic [3:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC,
        BS_SCAN,
        BS_LINK,
        BS_CHECK,
        BS_DEL,
        BS_RD_CHK,
        BS_RD_DATA,
        BS_DONE
    } back_state_t;

    typedef struct packed {
        logic [2:0]       command;
        logic [LEN_W-1:0] file_length;
        logic [7:0]       data_byte;
        logic [7:0]       block_index;
    } in_word_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       head_block;
        logic [7:0]       data_out;
        logic [LEN_W-1:0] size_out;
        logic             last_byte;
        logic [8:0]       free_blocks;
    } out_word_t;

    typedef struct packed {
        op_t              op;
        logic [LEN_W-1:0] file_length;
        logic [7:0]       data_byte;
        logic [7:0]       block_index;
    } item_t;

endpackage

// File: design/linked_block_chain_allocator_top.sv
// top level of the linked block chain allocator
`timescale 1ns / 1ps

// A pool of NUM_BLOCKS blocks of BLOCK_BYTES bytes holds files as linked chains.
// Each command word (create, write byte, open read, read byte, delete chain)
// gives exactly one result word. The front end decodes command words into a
// two entry queue, so it keeps taking words while the back end works; the back
// end runs one command at a time against a block table ram and a byte store
// ram and parks the result in an output register, so the next command can run
// while a result waits on a stalled receiver, up to the point where its own
// result is to be loaded. A read byte checks the block record, steps into the
// next block when the current one is used up and then fetches the byte; it
// gives no data when the next byte has not been written yet or no read is open.
// Create searches the block table one entry per cycle upwards from a
// lowest-free hint, passing over used blocks, and does not search at all when
// there is no room; a write byte that fills a block searches the same way and
// then links the new block to the old one. Delete walks the chain block by
// block. After reset the block table is cleared one entry per cycle before
// the first command runs (command words are queued meanwhile).

module linked_block_chain_allocator_top #(
    parameter int NUM_BLOCKS  = 256,
    parameter int BLOCK_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    // command word channel
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  lbca_pkg::in_word_t  cmd_word,
    // result word channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output lbca_pkg::out_word_t rsp_word
);

    // decoded command queue between front and back
    logic            q_valid;
    logic            q_pop;
    lbca_pkg::item_t q_item;

    lbca_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    // block table, byte store, cursors and result register
    lbca_back #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

// File: design/lbca_ram.sv
// generic single write, single read ram with registered read
`timescale 1ns / 1ps

module lbca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: design/lbca_front.sv
// front end: takes command words, decodes them and queues them for the back end
`timescale 1ns / 1ps

module lbca_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  lbca_pkg::in_word_t cmd_word,
    output logic               q_valid,
    input  logic               q_pop,
    output lbca_pkg::item_t    q_item
);

    lbca_pkg::item_t slot_reg [2];
    lbca_pkg::item_t dec;
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push, pop;

    always_comb
    begin
        dec.file_length = cmd_word.file_length;
        dec.data_byte   = cmd_word.data_byte;
        dec.block_index = cmd_word.block_index;
        case (cmd_word.command)
            lbca_pkg::CMD_CREATE: dec.op = lbca_pkg::OP_CREATE;
            lbca_pkg::CMD_WRITE:  dec.op = lbca_pkg::OP_WRITE;
            lbca_pkg::CMD_OPEN:   dec.op = lbca_pkg::OP_OPEN;
            lbca_pkg::CMD_READ:   dec.op = lbca_pkg::OP_READ;
            lbca_pkg::CMD_DELETE: dec.op = lbca_pkg::OP_DELETE;
            default:              dec.op = lbca_pkg::OP_NONE;
        endcase
    end

    assign cmd_stall = (count_reg == 2'd2);
    assign push      = cmd_valid && !cmd_stall;
    assign q_valid   = (count_reg != 2'd0);
    assign pop       = q_pop && q_valid;
    assign q_item    = slot_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// File: design/lbca_back.sv
// back end: block table, byte store, cursors and result register
`timescale 1ns / 1ps

module lbca_back #(
    parameter int NUM_BLOCKS  = 256,
    parameter int BLOCK_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  lbca_pkg::item_t     q_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output lbca_pkg::out_word_t rsp_word
);

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int FW = $clog2(BLOCK_BYTES + 1);
    localparam int AW = $clog2(NUM_BLOCKS * BLOCK_BYTES);
    localparam int LW = lbca_pkg::LEN_W;
    localparam int PW = CW + FW + LW;

    typedef struct packed {
        logic          in_use;
        logic [BW-1:0] owner;
        logic [FW-1:0] fill;
        logic [LW-1:0] len;
        logic [BW-1:0] nxt;
        logic          has_next;
    } rec_t;

    lbca_pkg::back_state_t state_reg, state_next;
    lbca_pkg::item_t       item_reg, item_next;
    logic [BW-1:0] cur_reg, cur_next;
    logic [BW-1:0] prev_reg, prev_next;
    logic [CW-1:0] hint_reg, hint_next;
    logic [CW-1:0] free_reg, free_next;
    logic          wr_open_reg, wr_open_next;
    logic [BW-1:0] wr_head_reg, wr_head_next;
    logic [BW-1:0] wr_block_reg, wr_block_next;
    logic [FW-1:0] wr_fill_reg, wr_fill_next;
    logic [LW-1:0] wr_done_reg, wr_done_next;
    logic [LW-1:0] wr_len_reg, wr_len_next;
    logic          rd_open_reg, rd_open_next;
    logic [BW-1:0] rd_head_reg, rd_head_next;
    logic [BW-1:0] rd_block_reg, rd_block_next;
    logic [FW-1:0] rd_off_reg, rd_off_next;
    logic [LW-1:0] rd_done_reg, rd_done_next;
    logic [LW-1:0] rd_len_reg, rd_len_next;
    lbca_pkg::status_t res_status_reg, res_status_next;
    logic [7:0]    res_head_reg, res_head_next;
    logic [7:0]    res_data_reg, res_data_next;
    logic [LW-1:0] res_size_reg, res_size_next;
    logic          res_last_reg, res_last_next;
    logic          out_valid_reg, out_valid_next;
    lbca_pkg::out_word_t out_word_reg, out_word_next;

    // ram ports
    logic          info_we;
    logic [BW-1:0] info_waddr;
    rec_t          info_wdata;
    rec_t          rec;
    logic          byte_we;
    logic [AW-1:0] byte_waddr, byte_raddr;
    logic [7:0]    byte_rdata;

    // shared terms
    logic [FW-1:0] fill1, off1;
    logic [LW-1:0] wdone1, rdone1;
    logic          space_ok, idx_in_range, can_load, follow, byte_ok;
    logic [BW-1:0] idx_b;
    logic [PW-1:0] cap;

    assign fill1        = wr_fill_reg + FW'(1);
    assign off1         = rd_off_reg + FW'(1);
    assign wdone1       = wr_done_reg + LW'(1);
    assign rdone1       = rd_done_reg + LW'(1);
    assign cap          = PW'(free_reg) * PW'(BLOCK_BYTES);
    assign space_ok     = cap > PW'(item_reg.file_length);
    assign idx_in_range = 32'(item_reg.block_index) < NUM_BLOCKS;
    assign idx_b        = BW'(item_reg.block_index);
    assign can_load     = !out_valid_reg || !rsp_stall;
    assign follow       = (rd_off_reg == FW'(BLOCK_BYTES)) && rec.has_next;
    assign byte_ok      = rd_off_reg < rec.fill;

    assign byte_waddr = AW'(wr_block_reg) * AW'(BLOCK_BYTES) + AW'(wr_fill_reg);
    assign byte_raddr = AW'(rd_block_reg) * AW'(BLOCK_BYTES) + AW'(rd_off_reg);

    assign q_pop     = (state_reg == lbca_pkg::BS_IDLE) && q_valid;
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    lbca_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (NUM_BLOCKS)
    ) u_info_ram (
        .clk     (clk),
        .wr_en   (info_we),
        .wr_addr (info_waddr),
        .wr_data (info_wdata),
        .rd_addr (cur_next),
        .rd_data (rec)
    );

    lbca_ram #(
        .WIDTH (8),
        .DEPTH (NUM_BLOCKS * BLOCK_BYTES)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_we),
        .wr_addr (byte_waddr),
        .wr_data (item_reg.data_byte),
        .rd_addr (byte_raddr),
        .rd_data (byte_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lbca_pkg::BS_CLEAR:
            begin
                if (cur_reg == BW'(NUM_BLOCKS - 1))
                begin
                    state_next = lbca_pkg::BS_IDLE;
                end
            end
            lbca_pkg::BS_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = lbca_pkg::BS_EXEC;
                end
            end
            lbca_pkg::BS_EXEC:
            begin
                state_next = lbca_pkg::BS_DONE;
                case (item_reg.op)
                    lbca_pkg::OP_CREATE:
                    begin
                        if (space_ok)
                        begin
                            state_next = lbca_pkg::BS_SCAN;
                        end
                    end
                    lbca_pkg::OP_WRITE:
                    begin
                        if (wr_open_reg && wdone1 < wr_len_reg
                            && fill1 == FW'(BLOCK_BYTES) && free_reg != '0)
                        begin
                            state_next = lbca_pkg::BS_SCAN;
                        end
                    end
                    lbca_pkg::OP_OPEN, lbca_pkg::OP_DELETE:
                    begin
                        if (idx_in_range)
                        begin
                            state_next = lbca_pkg::BS_CHECK;
                        end
                    end
                    lbca_pkg::OP_READ:
                    begin
                        if (rd_open_reg)
                        begin
                            state_next = lbca_pkg::BS_RD_CHK;
                        end
                    end
                    default: state_next = lbca_pkg::BS_DONE;
                endcase
            end
            lbca_pkg::BS_SCAN:
            begin
                if (!rec.in_use)
                begin
                    state_next = (item_reg.op == lbca_pkg::OP_WRITE) ?
                                 lbca_pkg::BS_LINK : lbca_pkg::BS_DONE;
                end
            end
            lbca_pkg::BS_LINK: state_next = lbca_pkg::BS_DONE;
            lbca_pkg::BS_CHECK:
            begin
                if (!rec.in_use || rec.owner != idx_b
                    || item_reg.op != lbca_pkg::OP_DELETE)
                begin
                    state_next = lbca_pkg::BS_DONE;
                end
                else
                begin
                    state_next = lbca_pkg::BS_DEL;
                end
            end
            lbca_pkg::BS_DEL:
            begin
                if (!rec.has_next)
                begin
                    state_next = lbca_pkg::BS_DONE;
                end
            end
            lbca_pkg::BS_RD_CHK:
            begin
                if (!follow)
                begin
                    state_next = byte_ok ? lbca_pkg::BS_RD_DATA : lbca_pkg::BS_DONE;
                end
            end
            lbca_pkg::BS_RD_DATA: state_next = lbca_pkg::BS_DONE;
            lbca_pkg::BS_DONE:
            begin
                if (can_load)
                begin
                    state_next = lbca_pkg::BS_IDLE;
                end
            end
            default: state_next = lbca_pkg::BS_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        item_next       = item_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        hint_next       = hint_reg;
        free_next       = free_reg;
        wr_open_next    = wr_open_reg;
        wr_head_next    = wr_head_reg;
        wr_block_next   = wr_block_reg;
        wr_fill_next    = wr_fill_reg;
        wr_done_next    = wr_done_reg;
        wr_len_next     = wr_len_reg;
        rd_open_next    = rd_open_reg;
        rd_head_next    = rd_head_reg;
        rd_block_next   = rd_block_reg;
        rd_off_next     = rd_off_reg;
        rd_done_next    = rd_done_reg;
        rd_len_next     = rd_len_reg;
        res_status_next = res_status_reg;
        res_head_next   = res_head_reg;
        res_data_next   = res_data_reg;
        res_size_next   = res_size_reg;
        res_last_next   = res_last_reg;
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        info_we         = 1'b0;
        info_waddr      = cur_reg;
        info_wdata      = '0;
        byte_we         = 1'b0;

        case (state_reg)
            lbca_pkg::BS_CLEAR:
            begin
                info_we  = 1'b1;
                cur_next = cur_reg + BW'(1);
            end
            lbca_pkg::BS_IDLE:
            begin
                if (q_valid)
                begin
                    item_next       = q_item;
                    res_status_next = lbca_pkg::ST_OK;
                    res_head_next   = '0;
                    res_data_next   = '0;
                    res_size_next   = '0;
                    res_last_next   = 1'b0;
                end
            end
            lbca_pkg::BS_EXEC:
            begin
                case (item_reg.op)
                    lbca_pkg::OP_CREATE:
                    begin
                        if (space_ok)
                        begin
                            cur_next = BW'(hint_reg);
                        end
                        else
                        begin
                            res_status_next = lbca_pkg::ST_NO_SPACE;
                        end
                    end
                    lbca_pkg::OP_WRITE:
                    begin
                        if (!wr_open_reg)
                        begin
                            res_status_next = lbca_pkg::ST_NO_XFER;
                        end
                        else
                        begin
                            byte_we          = 1'b1;
                            wr_fill_next     = fill1;
                            wr_done_next     = wdone1;
                            info_we          = 1'b1;
                            info_waddr       = wr_block_reg;
                            info_wdata.in_use = 1'b1;
                            info_wdata.owner = wr_head_reg;
                            info_wdata.fill  = fill1;
                            info_wdata.len   = wr_len_reg;
                            if (wdone1 >= wr_len_reg)
                            begin
                                res_last_next = 1'b1;
                                wr_open_next  = 1'b0;
                            end
                            else if (fill1 == FW'(BLOCK_BYTES))
                            begin
                                if (free_reg == '0)
                                begin
                                    res_status_next = lbca_pkg::ST_NO_SPACE;
                                    wr_open_next    = 1'b0;
                                end
                                else
                                begin
                                    // old block record gets its link once the new one is found
                                    info_we   = 1'b0;
                                    prev_next = wr_block_reg;
                                    cur_next  = BW'(hint_reg);
                                end
                            end
                        end
                    end
                    lbca_pkg::OP_OPEN, lbca_pkg::OP_DELETE:
                    begin
                        if (idx_in_range)
                        begin
                            cur_next = idx_b;
                        end
                        else
                        begin
                            res_status_next = lbca_pkg::ST_UNUSED;
                        end
                    end
                    lbca_pkg::OP_READ:
                    begin
                        if (rd_open_reg)
                        begin
                            cur_next = rd_block_reg;
                        end
                        else
                        begin
                            res_status_next = lbca_pkg::ST_NO_XFER;
                        end
                    end
                    default: res_status_next = lbca_pkg::ST_OK;
                endcase
            end
            lbca_pkg::BS_SCAN:
            begin
                if (rec.in_use)
                begin
                    cur_next = cur_reg + BW'(1);
                end
                else
                begin
                    info_we           = 1'b1;
                    info_wdata.in_use = 1'b1;
                    free_next         = free_reg - CW'(1);
                    hint_next         = CW'(cur_reg) + CW'(1);
                    if (item_reg.op == lbca_pkg::OP_WRITE)
                    begin
                        info_wdata.owner = wr_head_reg;
                        info_wdata.len   = wr_len_reg;
                        wr_block_next    = cur_reg;
                        wr_fill_next     = '0;
                    end
                    else
                    begin
                        info_wdata.owner = cur_reg;
                        info_wdata.len   = item_reg.file_length;
                        res_head_next    = 8'(cur_reg);
                        wr_open_next     = (item_reg.file_length != '0);
                        wr_head_next     = cur_reg;
                        wr_block_next    = cur_reg;
                        wr_fill_next     = '0;
                        wr_done_next     = '0;
                        wr_len_next      = item_reg.file_length;
                    end
                end
            end
            lbca_pkg::BS_LINK:
            begin
                info_we             = 1'b1;
                info_waddr          = prev_reg;
                info_wdata.in_use   = 1'b1;
                info_wdata.owner    = wr_head_reg;
                info_wdata.fill     = FW'(BLOCK_BYTES);
                info_wdata.len      = wr_len_reg;
                info_wdata.nxt      = wr_block_reg;
                info_wdata.has_next = 1'b1;
            end
            lbca_pkg::BS_CHECK:
            begin
                if (!rec.in_use)
                begin
                    res_status_next = lbca_pkg::ST_UNUSED;
                end
                else if (rec.owner != idx_b)
                begin
                    res_status_next = lbca_pkg::ST_NOT_HEAD;
                end
                else if (item_reg.op == lbca_pkg::OP_OPEN)
                begin
                    res_size_next = rec.len;
                    rd_open_next  = (rec.len != '0);
                    rd_head_next  = idx_b;
                    rd_block_next = idx_b;
                    rd_off_next   = '0;
                    rd_done_next  = '0;
                    rd_len_next   = rec.len;
                end
            end
            lbca_pkg::BS_DEL:
            begin
                // free this block and step along the chain
                info_we          = 1'b1;
                info_wdata.owner = rec.owner;
                if (rec.in_use)
                begin
                    free_next = free_reg + CW'(1);
                    if (CW'(cur_reg) < hint_reg)
                    begin
                        hint_next = CW'(cur_reg);
                    end
                end
                if (rec.has_next)
                begin
                    cur_next = rec.nxt;
                end
                else
                begin
                    if (wr_open_reg && wr_head_reg == idx_b)
                    begin
                        wr_open_next = 1'b0;
                    end
                    if (rd_open_reg && rd_head_reg == idx_b)
                    begin
                        rd_open_next = 1'b0;
                    end
                end
            end
            lbca_pkg::BS_RD_CHK:
            begin
                if (follow)
                begin
                    rd_block_next = rec.nxt;
                    rd_off_next   = '0;
                    cur_next      = rec.nxt;
                end
                else if (byte_ok)
                begin
                    rd_off_next  = off1;
                    rd_done_next = rdone1;
                    if (rdone1 >= rd_len_reg)
                    begin
                        res_last_next = 1'b1;
                        rd_open_next  = 1'b0;
                    end
                end
                else
                begin
                    res_status_next = lbca_pkg::ST_NO_XFER;
                end
            end
            lbca_pkg::BS_RD_DATA:
            begin
                res_data_next = byte_rdata;
            end
            lbca_pkg::BS_DONE:
            begin
                if (can_load)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.status      = res_status_reg;
                    out_word_next.head_block  = res_head_reg;
                    out_word_next.data_out    = res_data_reg;
                    out_word_next.size_out    = res_size_reg;
                    out_word_next.last_byte   = res_last_reg;
                    out_word_next.free_blocks = 9'(free_reg);
                end
            end
            default: cur_next = cur_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lbca_pkg::BS_CLEAR;
            cur_reg       <= '0;
            hint_reg      <= '0;
            free_reg      <= CW'(NUM_BLOCKS);
            wr_open_reg   <= 1'b0;
            rd_open_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            hint_reg      <= hint_next;
            free_reg      <= free_next;
            wr_open_reg   <= wr_open_next;
            rd_open_reg   <= rd_open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        prev_reg       <= prev_next;
        wr_head_reg    <= wr_head_next;
        wr_block_reg   <= wr_block_next;
        wr_fill_reg    <= wr_fill_next;
        wr_done_reg    <= wr_done_next;
        wr_len_reg     <= wr_len_next;
        rd_head_reg    <= rd_head_next;
        rd_block_reg   <= rd_block_next;
        rd_off_reg     <= rd_off_next;
        rd_done_reg    <= rd_done_next;
        rd_len_reg     <= rd_len_next;
        res_status_reg <= res_status_next;
        res_head_reg   <= res_head_next;
        res_data_reg   <= res_data_next;
        res_size_reg   <= res_size_next;
        res_last_reg   <= res_last_next;
        out_word_reg   <= out_word_next;
    end

endmodule
